>>> src/id3_pkg.sv
`timescale 1ns / 1ps
// id3_pkg: shared types, constants and helpers for the ID3v2 tag deframer.
// No dependencies; imported by every module of the block.
package id3_pkg;

	// parser phase, one-hot
	typedef enum logic [5:0] {
		PH_TAG     = 6'b000001,
		PH_EXT     = 6'b000010,
		PH_SKIP    = 6'b000100,
		PH_FRAME   = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_DONE    = 6'b100000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_TAG     = 2'd0,
		KIND_FRAME   = 2'd1,
		KIND_PAYLOAD = 2'd2,
		KIND_END     = 2'd3
	} kind_t;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned ID_W   = 32;
	localparam int unsigned SIZE_W = 28;
	localparam int unsigned CNT_W  = 4;

	// byte positions inside a header, counted from 1
	localparam logic [CNT_W-1:0] POS_FIRST    = 4'd1;
	localparam logic [CNT_W-1:0] POS_VERSION  = 4'd4;
	localparam logic [CNT_W-1:0] POS_REVISION = 4'd5;
	localparam logic [CNT_W-1:0] POS_FLAGS    = 4'd6;
	localparam logic [CNT_W-1:0] POS_SIZE0    = 4'd7;
	localparam logic [CNT_W-1:0] POS_ID_LAST  = 4'd4;
	localparam logic [CNT_W-1:0] POS_SZ_LAST  = 4'd8;
	localparam logic [CNT_W-1:0] POS_FLAG1    = 4'd9;
	localparam logic [CNT_W-1:0] HDR_LEN      = 4'd10;
	localparam logic [CNT_W-1:0] EXT_LEN      = 4'd4;

	// tag flag bit 6 sits at bit 2 of the held upper nibble
	localparam int unsigned EXT_FLAG_BIT = 2;

	typedef struct packed {
		kind_t              kind;
		logic [ID_W-1:0]    frame_id;
		logic [SIZE_W-1:0]  size_value;
		logic [BYTE_W-1:0]  tag_version;
		logic [BYTE_W-1:0]  tag_revision;
		logic [3:0]         tag_flag_bits;
		logic [BYTE_W-1:0]  frame_flag_bits;
		logic [BYTE_W-1:0]  payload_byte;
		logic [SIZE_W-1:0]  payload_offset;
		logic               last_of_frame;
	} result_t;

	typedef struct packed {
		phase_t            phase;
		logic [CNT_W-1:0]  header_count;
	} core_status_t;

	// shift one syncsafe byte (7 data bits) into the size accumulator
	function automatic logic [SIZE_W-1:0] sync_in(input logic [SIZE_W-1:0] acc,
			input logic [BYTE_W-1:0] b);
		return {acc[SIZE_W-8:0], b[6:0]};
	endfunction

	// 'A'..'Z' or '0'..'9'
	function automatic logic id_char_ok(input logic [BYTE_W-1:0] c);
		return c inside {[8'h41:8'h5A], [8'h30:8'h39]};
	endfunction

	function automatic logic id_ok(input logic [ID_W-1:0] id);
		return id_char_ok(id[31:24]) && id_char_ok(id[23:16]) &&
			id_char_ok(id[15:8]) && id_char_ok(id[7:0]);
	endfunction

endpackage

>>> src/id3_ban_regs.sv
`timescale 1ns / 1ps
// id3_ban_regs: banned frame ID registers and the ID match against them.
// Depends on id3_pkg.
module id3_ban_regs import id3_pkg::*; #(
	parameter int unsigned NUM_BANNED = 4,
	parameter int unsigned IDX_W      = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [ID_W-1:0]  cfg_data,
	input  logic [ID_W-1:0]  id,
	output logic             banned
);

	logic [ID_W-1:0] ban_q [NUM_BANNED];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_BANNED; k++) ban_q[k] <= '0;
		end else if (cfg_we) begin
			for (int k = 0; k < NUM_BANNED; k++) begin
				if (cfg_index == IDX_W'(k)) ban_q[k] <= cfg_data;
			end
		end
	end

	// zero entry means unused
	always_comb begin
		banned = 1'b0;
		for (int k = 0; k < NUM_BANNED; k++) begin
			if ((ban_q[k] != '0) && (ban_q[k] == id)) banned = 1'b1;
		end
	end

endmodule

>>> src/id3_parse_core.sv
`timescale 1ns / 1ps
// id3_parse_core: parser state and next-state/result logic for one byte beat.
// Depends on id3_pkg; the ban match comes from id3_ban_regs.
module id3_parse_core import id3_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic [BYTE_W-1:0]  byte_in,
	input  logic               start,
	input  logic               banned,
	output logic [ID_W-1:0]    id,
	output logic               res_valid,
	output result_t            res,
	output core_status_t       status
);

	phase_t             phase_q, phase_d, eph;
	logic [CNT_W-1:0]   count_q, count_d, ecnt, n;
	logic [ID_W-1:0]    id_q, id_d;
	logic [SIZE_W-1:0]  acc_q, acc_d, eacc;
	logic [SIZE_W-1:0]  rem_q, rem_d, rem_dec;
	logic [SIZE_W-1:0]  off_q, off_d;
	logic [BYTE_W-1:0]  ver_q, ver_d, rev_q, rev_d;
	logic [3:0]         tflags_q, tflags_d;
	logic [BYTE_W-1:0]  fflags_q, fflags_d;

	assign id      = id_q;
	assign rem_dec = rem_q - SIZE_W'(1);

	always_comb begin
		// start mark restarts the tag header before the byte is taken
		eph  = start ? PH_TAG : phase_q;
		ecnt = start ? '0 : count_q;
		eacc = start ? '0 : acc_q;
		n    = ecnt + CNT_W'(1);

		phase_d   = eph;
		count_d   = ecnt;
		acc_d     = eacc;
		id_d      = id_q;
		rem_d     = rem_q;
		off_d     = off_q;
		ver_d     = ver_q;
		rev_d     = rev_q;
		tflags_d  = tflags_q;
		fflags_d  = fflags_q;
		res_valid = 1'b0;
		res       = '0;

		case (eph)
			PH_TAG: begin
				count_d = n;
				if (n == POS_FIRST) acc_d = '0;
				if (n == POS_VERSION) ver_d = byte_in;
				else if (n == POS_REVISION) rev_d = byte_in;
				else if (n == POS_FLAGS) tflags_d = byte_in[7:4];
				else if (n >= POS_SIZE0) acc_d = sync_in(eacc, byte_in);
				if (n >= HDR_LEN) begin
					res_valid         = 1'b1;
					res.kind          = KIND_TAG;
					res.size_value    = sync_in(eacc, byte_in);
					res.tag_version   = ver_q;
					res.tag_revision  = rev_q;
					res.tag_flag_bits = tflags_q;
					count_d = '0;
					acc_d   = '0;
					phase_d = tflags_q[EXT_FLAG_BIT] ? PH_EXT : PH_FRAME;
				end
			end
			PH_EXT: begin
				count_d = n;
				acc_d   = sync_in(eacc, byte_in);
				if (n >= EXT_LEN) begin
					rem_d = acc_d;
					if (acc_d != '0) begin
						phase_d = PH_SKIP;
					end else begin
						phase_d = PH_FRAME;
						count_d = '0;
					end
				end
			end
			PH_SKIP: begin
				rem_d = rem_dec;
				if (rem_dec == '0) begin
					phase_d = PH_FRAME;
					count_d = '0;
				end
			end
			PH_FRAME: begin
				count_d = n;
				if (n <= POS_ID_LAST) begin
					if (n == POS_FIRST) begin
						acc_d    = '0;
						fflags_d = '0;
					end
					id_d = {id_q[ID_W-9:0], byte_in};
				end else if (n <= POS_SZ_LAST) begin
					acc_d = sync_in(eacc, byte_in);
				end else if (n == POS_FLAG1) begin
					fflags_d = {byte_in[6:4], 5'b0};
				end else begin
					fflags_d = fflags_q | {3'b0, byte_in[6], byte_in[3:0]};
					count_d  = '0;
					if (!id_ok(id_q)) begin
						res_valid    = 1'b1;
						res.kind     = KIND_END;
						res.frame_id = id_q;
						phase_d      = PH_DONE;
					end else begin
						rem_d = eacc;
						off_d = '0;
						if (banned) begin
							phase_d = (eacc != '0) ? PH_SKIP : PH_FRAME;
						end else begin
							res_valid           = 1'b1;
							res.kind            = KIND_FRAME;
							res.frame_id        = id_q;
							res.size_value      = eacc;
							res.frame_flag_bits = fflags_d;
							phase_d = (eacc != '0) ? PH_PAYLOAD : PH_FRAME;
						end
					end
				end
			end
			PH_PAYLOAD: begin
				res_valid          = 1'b1;
				res.kind           = KIND_PAYLOAD;
				res.frame_id       = id_q;
				res.payload_byte   = byte_in;
				res.payload_offset = off_q;
				res.last_of_frame  = (rem_q == SIZE_W'(1));
				rem_d = rem_dec;
				off_d = off_q + SIZE_W'(1);
				if (rem_dec == '0) begin
					phase_d = PH_FRAME;
					count_d = '0;
				end
			end
			PH_DONE: begin
				// ignore bytes until the next start mark
			end
			default: begin
				phase_d = PH_TAG;
				count_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TAG;
			count_q  <= '0;
			id_q     <= '0;
			acc_q    <= '0;
			rem_q    <= '0;
			off_q    <= '0;
			ver_q    <= '0;
			rev_q    <= '0;
			tflags_q <= '0;
			fflags_q <= '0;
		end else if (advance) begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			id_q     <= id_d;
			acc_q    <= acc_d;
			rem_q    <= rem_d;
			off_q    <= off_d;
			ver_q    <= ver_d;
			rev_q    <= rev_d;
			tflags_q <= tflags_d;
			fflags_q <= fflags_d;
		end
	end

	assign status.phase        = phase_q;
	assign status.header_count = count_q;

endmodule

>>> src/id3_tag_deframer.sv
`timescale 1ns / 1ps
// id3v2_tag_deframer: top level; input register, parser core, ban registers
// and result register. Depends on id3_pkg, id3_ban_regs, id3_parse_core.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one tag byte per beat, with
//   start_of_tag marking byte 1 of a new tag header. Output channel
//   (out_valid / out_stall) carries at most one result beat per input beat:
//   tag header, frame header, payload byte or end of frames.
//   Config: cfg_we writes cfg_data into ban register cfg_index; indexes at
//   or beyond NUM_BANNED are dropped. Write only while the block is idle.
// Timing:
//   Each input beat passes the input register, then the parse logic into
//   the result register. Throughput is one byte per cycle while out_stall
//   holds back no result, set by the parser state update.
// Stall:
//   When out_stall holds a full result register, the input register still
//   takes one more beat; in_stall rises only when that one is also held.
//   Bytes that give no result pass the parser regardless of out_stall.
// Reset:
//   arst_n clears the ban registers, pipeline valids and parser state; the
//   parser then treats the first bytes as a tag header.
module id3v2_tag_deframer import id3_pkg::*; #(
	parameter int unsigned NUM_BANNED = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// config write port
	input  logic                     cfg_we,
	input  logic [$clog2(NUM_BANNED):0] cfg_index,
	input  logic [ID_W-1:0]          cfg_data,
	// input channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [BYTE_W-1:0]        in_byte,
	input  logic                     start_of_tag,
	// output channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               kind,
	output logic [ID_W-1:0]          frame_id,
	output logic [SIZE_W-1:0]        size_value,
	output logic [BYTE_W-1:0]        tag_version,
	output logic [BYTE_W-1:0]        tag_revision,
	output logic [3:0]               tag_flag_bits,
	output logic [BYTE_W-1:0]        frame_flag_bits,
	output logic [BYTE_W-1:0]        payload_byte,
	output logic [SIZE_W-1:0]        payload_offset,
	output logic                     last_of_frame
);

	localparam int unsigned IDX_W = $clog2(NUM_BANNED) + 1;

	// input register stage
	logic               valid_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic               start_s1;

	// result register
	logic               out_valid_q;
	result_t            out_q;

	logic               advance;
	logic               in_take;
	logic               banned;
	logic [ID_W-1:0]    cur_id;
	logic               res_valid;
	result_t            res;
	core_status_t       status;

	// a byte leaves stage 1 if it makes no result or the result slot frees up
	assign advance  = valid_s1 && (!res_valid || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1  <= in_byte;
			start_s1 <= start_of_tag;
		end
	end

	id3_ban_regs #(
		.NUM_BANNED (NUM_BANNED),
		.IDX_W      (IDX_W)
	) u_ban (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.id        (cur_id),
		.banned    (banned)
	);

	id3_parse_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.byte_in   (byte_s1),
		.start     (start_s1),
		.banned    (banned),
		.id        (cur_id),
		.res_valid (res_valid),
		.res       (res),
		.status    (status)
	);

	// result register: load on a result beat, drain when the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) out_q <= res;
	end

	assign out_valid       = out_valid_q;
	assign kind            = out_q.kind;
	assign frame_id        = out_q.frame_id;
	assign size_value      = out_q.size_value;
	assign tag_version     = out_q.tag_version;
	assign tag_revision    = out_q.tag_revision;
	assign tag_flag_bits   = out_q.tag_flag_bits;
	assign frame_flag_bits = out_q.frame_flag_bits;
	assign payload_byte    = out_q.payload_byte;
	assign payload_offset  = out_q.payload_offset;
	assign last_of_frame   = out_q.last_of_frame;

`ifndef SYNTHESIS
	// a held stage-1 beat is neither lost nor altered
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1) && $stable(start_s1)))
		else $error("stage-1 beat dropped or changed while held");

	// a frame header with nonzero size leads into payload streaming
	a_frame_to_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_valid && (res.kind == KIND_FRAME) && (res.size_value != '0))
		|=> (status.phase == PH_PAYLOAD))
		else $error("frame header not followed by payload phase");

	// header byte counter never runs past a full header
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		status.header_count <= HDR_LEN)
		else $error("header counter out of range");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for id3v2_tag_deframer; a local tag parser model
// predicts every result beat. Depends on id3_pkg and the deframer RTL only.
module tb;
	import id3_pkg::*;

	localparam int unsigned NUM_BANNED = 4;
	localparam int unsigned IDX_W      = $clog2(NUM_BANNED) + 1;
	localparam int unsigned BAN_SEL_W  = $clog2(NUM_BANNED);

	// config register map; indexes past the ban words must be dropped by the block
	localparam int unsigned REG_BAN_ID_0 = 0;
	localparam int unsigned REG_BAN_ID_1 = 1;
	localparam int unsigned REG_BAN_ID_2 = 2;
	localparam int unsigned REG_BAN_ID_3 = 3;
	localparam int unsigned REG_NONE_LO  = 4;
	localparam int unsigned REG_NONE_HI  = 7;

	localparam int unsigned IDLE_PCT    = 34;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned HOLD_AT     = 700;   // accepted beats before the long hold-off
	localparam int unsigned CALM_LO     = 1000;  // no random idling in [CALM_LO, CALM_HI)
	localparam int unsigned CALM_HI     = 1300;
	localparam int unsigned PHASE_BYTES = 270;   // random bytes per ban setting
	localparam int unsigned NUM_PHASES  = 5;

	// one input beat
	typedef struct packed {
		logic              sot;
		logic [BYTE_W-1:0] data;
	} tag_beat_t;

	// ---------------------------------------------------------------- signals
	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                cfg_we       = 1'b0;
	logic [IDX_W-1:0]    cfg_index    = '0;
	logic [ID_W-1:0]     cfg_data     = '0;
	logic                in_valid     = 1'b0;
	logic                in_stall;
	logic [BYTE_W-1:0]   in_byte      = '0;
	logic                start_of_tag = 1'b0;
	logic                out_valid;
	logic                out_stall    = 1'b0;
	logic [1:0]          kind;
	logic [ID_W-1:0]     frame_id;
	logic [SIZE_W-1:0]   size_value;
	logic [BYTE_W-1:0]   tag_version;
	logic [BYTE_W-1:0]   tag_revision;
	logic [3:0]          tag_flag_bits;
	logic [BYTE_W-1:0]   frame_flag_bits;
	logic [BYTE_W-1:0]   payload_byte;
	logic [SIZE_W-1:0]   payload_offset;
	logic                last_of_frame;

	id3v2_tag_deframer #(
		.NUM_BANNED(NUM_BANNED)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.start_of_tag   (start_of_tag),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.frame_id       (frame_id),
		.size_value     (size_value),
		.tag_version    (tag_version),
		.tag_revision   (tag_revision),
		.tag_flag_bits  (tag_flag_bits),
		.frame_flag_bits(frame_flag_bits),
		.payload_byte   (payload_byte),
		.payload_offset (payload_offset),
		.last_of_frame  (last_of_frame)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------ bookkeeping
	tag_beat_t   tag_bytes[$];       // beats waiting to be offered
	result_t     parsed_records[$];  // results the parser model has produced
	int unsigned accepted_cnt = 0;
	int unsigned hold_left    = 0;
	bit          hold_done    = 1'b0;
	int unsigned error_cnt    = 0;
	int unsigned stream_len   = 0;
	int unsigned kind_seen[4] = '{0, 0, 0, 0};

	// frame IDs used most of the time, so bans actually hit
	logic [ID_W-1:0] id_pool[8] = '{"TIT2", "TPE1", "APIC", "COMM",
		"PRIV", "TXXX", "A0Z9", "9ZA0"};
	// bytes that break a frame ID: just outside the ranges, lower case, extremes
	logic [BYTE_W-1:0] bad_chars[9] = '{8'h00, "@", "[", "/", ":", "a", "z",
		8'h80, 8'hFF};

	// --------------------------------------------------------- parser model
	phase_t            ph       = PH_TAG;
	logic [CNT_W-1:0]  hdr_cnt  = '0;
	logic [ID_W-1:0]   id_sr    = '0;
	logic [SIZE_W-1:0] size_acc = '0;
	logic [SIZE_W-1:0] remain   = '0;
	logic [SIZE_W-1:0] offs     = '0;
	logic [BYTE_W-1:0] ver      = '0;
	logic [BYTE_W-1:0] rev      = '0;
	logic [3:0]        tflags   = '0;
	logic [BYTE_W-1:0] fflags   = '0;
	logic [ID_W-1:0]   ban_word[NUM_BANNED] = '{default: '0};

	function automatic bit is_id_char(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
	endfunction

	function automatic bit id_legal(input logic [ID_W-1:0] id);
		return is_id_char(id[31:24]) && is_id_char(id[23:16]) &&
			is_id_char(id[15:8]) && is_id_char(id[7:0]);
	endfunction

	function automatic bit id_barred(input logic [ID_W-1:0] id);
		for (int k = 0; k < NUM_BANNED; k++)
			if (ban_word[k] != '0 && ban_word[k] == id)
				return 1'b1;
		return 1'b0;
	endfunction

	// Advance the model by one accepted byte; queue the result it causes, if any.
	task automatic deframe_byte(input logic [7:0] b, input logic sot);
		logic [CNT_W-1:0] n;
		result_t rec;
		bit emit;
		rec = '0;
		emit = 1'b0;
		if (sot) begin
			ph = PH_TAG;
			hdr_cnt = '0;
			size_acc = '0;
		end
		case (ph)
			PH_TAG: begin
				n = hdr_cnt + 1'b1;
				hdr_cnt = n;
				if (n == POS_FIRST)
					size_acc = '0;
				if (n == POS_VERSION)
					ver = b;
				else if (n == POS_REVISION)
					rev = b;
				else if (n == POS_FLAGS)
					tflags = b[7:4];
				else if (n >= POS_SIZE0)
					size_acc = {size_acc[SIZE_W-8:0], b[6:0]};
				if (n >= HDR_LEN) begin
					rec.kind = KIND_TAG;
					rec.size_value = size_acc;
					rec.tag_version = ver;
					rec.tag_revision = rev;
					rec.tag_flag_bits = tflags;
					emit = 1'b1;
					hdr_cnt = '0;
					size_acc = '0;
					ph = tflags[EXT_FLAG_BIT] ? PH_EXT : PH_FRAME;
				end
			end
			PH_EXT: begin
				n = hdr_cnt + 1'b1;
				hdr_cnt = n;
				size_acc = {size_acc[SIZE_W-8:0], b[6:0]};
				if (n >= EXT_LEN) begin
					remain = size_acc;
					if (remain != '0) begin
						ph = PH_SKIP;
					end else begin
						ph = PH_FRAME;
						hdr_cnt = '0;
					end
				end
			end
			PH_SKIP: begin
				remain = remain - 1'b1;
				if (remain == '0) begin
					ph = PH_FRAME;
					hdr_cnt = '0;
				end
			end
			PH_FRAME: begin
				n = hdr_cnt + 1'b1;
				hdr_cnt = n;
				if (n == POS_FIRST) begin
					size_acc = '0;
					fflags = '0;
				end
				if (n <= POS_ID_LAST) begin
					id_sr = {id_sr[23:0], b};
				end else if (n <= POS_SZ_LAST) begin
					size_acc = {size_acc[SIZE_W-8:0], b[6:0]};
				end else if (n == POS_FLAG1) begin
					fflags = {b[6:4], 5'b0};
				end else begin
					fflags = fflags | {3'b0, b[6], b[3:0]};
					hdr_cnt = '0;
					if (!id_legal(id_sr)) begin
						rec.kind = KIND_END;
						rec.frame_id = id_sr;
						emit = 1'b1;
						ph = PH_DONE;
					end else begin
						remain = size_acc;
						offs = '0;
						if (id_barred(id_sr)) begin
							// banned: payload is swallowed silently
							ph = (remain != '0) ? PH_SKIP : PH_FRAME;
						end else begin
							rec.kind = KIND_FRAME;
							rec.frame_id = id_sr;
							rec.size_value = size_acc;
							rec.frame_flag_bits = fflags;
							emit = 1'b1;
							ph = (remain != '0) ? PH_PAYLOAD : PH_FRAME;
						end
					end
				end
			end
			PH_PAYLOAD: begin
				rec.kind = KIND_PAYLOAD;
				rec.frame_id = id_sr;
				rec.payload_byte = b;
				rec.payload_offset = offs;
				rec.last_of_frame = (remain == 28'd1);
				emit = 1'b1;
				remain = remain - 1'b1;
				offs = offs + 1'b1;
				if (remain == '0) begin
					ph = PH_FRAME;
					hdr_cnt = '0;
				end
			end
			default: ;  // after an illegal ID: wait for a start mark
		endcase
		if (emit)
			parsed_records = {parsed_records, rec};
	endtask

	// ------------------------------------------------------------ reporting
	function automatic string show(input result_t r);
		return $sformatf("kind=%0d id=%h size=%h ver=%h rev=%h tf=%h ff=%h pb=%h off=%h last=%b",
			r.kind, r.frame_id, r.size_value, r.tag_version, r.tag_revision,
			r.tag_flag_bits, r.frame_flag_bits, r.payload_byte, r.payload_offset,
			r.last_of_frame);
	endfunction

	task automatic flag(input string msg);
		error_cnt++;
		if (error_cnt <= 10)
			$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	// random idling, suspended for a calm window in the middle of the run
	function automatic bit take_break();
		if (accepted_cnt >= CALM_LO && accepted_cnt < CALM_HI)
			return 1'b0;
		return $urandom_range(99) < IDLE_PCT;
	endfunction

	// --------------------------------------------------------------- driver
	// Offers queued beats; holds a stalled beat unchanged; predicts on accept.
	always @(posedge clk) begin : drv
		tag_beat_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				deframe_byte(in_byte, start_of_tag);
				accepted_cnt <= accepted_cnt + 1;
			end
			if (!in_valid || !in_stall) begin
				if (tag_bytes.size() != 0 && !take_break()) begin
					nxt = tag_bytes.pop_front();
					in_valid <= 1'b1;
					in_byte <= nxt.data;
					start_of_tag <= nxt.sot;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, once, so the block backs up into in_stall
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// -------------------------------------------------------------- monitor
	always @(posedge clk) begin : mon
		result_t got;
		result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got.kind = kind_t'(kind);
				got.frame_id = frame_id;
				got.size_value = size_value;
				got.tag_version = tag_version;
				got.tag_revision = tag_revision;
				got.tag_flag_bits = tag_flag_bits;
				got.frame_flag_bits = frame_flag_bits;
				got.payload_byte = payload_byte;
				got.payload_offset = payload_offset;
				got.last_of_frame = last_of_frame;
				kind_seen[kind]++;
				if (parsed_records.size() == 0) begin
					flag({"unexpected beat: ", show(got)});
				end else begin
					want = parsed_records.pop_front();
					if (got.kind !== want.kind || got.frame_id !== want.frame_id ||
							got.size_value !== want.size_value ||
							got.tag_version !== want.tag_version ||
							got.tag_revision !== want.tag_revision ||
							got.tag_flag_bits !== want.tag_flag_bits ||
							got.frame_flag_bits !== want.frame_flag_bits ||
							got.payload_byte !== want.payload_byte ||
							got.payload_offset !== want.payload_offset ||
							got.last_of_frame !== want.last_of_frame)
						flag({"\n  exp ", show(want), "\n  got ", show(got)});
				end
			end
			out_stall <= (hold_left != 0) || take_break();
		end
	end

	// ------------------------------------------------------------- stimulus
	task automatic put(input logic [7:0] b, input logic sot);
		tag_beat_t bt;
		bt.sot = sot;
		bt.data = b;
		tag_bytes = {tag_bytes, bt};
		stream_len++;
	endtask

	task automatic put_syncsafe(input logic [SIZE_W-1:0] v, input bit rand_msb);
		for (int k = 3; k >= 0; k--)
			put({rand_msb ? 1'($urandom_range(1)) : 1'b1, v[7*k +: 7]}, 1'b0);
	endtask

	task automatic put_tag_hdr(input logic sot, input logic [7:0] v, input logic [7:0] r,
			input logic [7:0] fl, input logic [SIZE_W-1:0] sz, input bit rand_msb);
		put(8'($urandom_range(255)), sot);  // bytes 1..3 are not checked
		put(8'($urandom_range(255)), 1'b0);
		put(8'($urandom_range(255)), 1'b0);
		put(v, 1'b0);
		put(r, 1'b0);
		put(fl, 1'b0);
		put_syncsafe(sz, rand_msb);
	endtask

	task automatic put_frame_hdr(input logic [ID_W-1:0] id, input logic [SIZE_W-1:0] sz,
			input logic [7:0] f1, input logic [7:0] f2);
		for (int k = 3; k >= 0; k--)
			put(id[8*k +: 8], 1'b0);
		put_syncsafe(sz, 1'b1);
		put(f1, 1'b0);
		put(f2, 1'b0);
	endtask

	task automatic put_payload(input int unsigned n);
		repeat (n) put(8'($urandom_range(255)), 1'b0);
	endtask

	function automatic logic [7:0] pick_id_char();
		int unsigned r;
		r = $urandom_range(35);
		return (r < 26) ? 8'("A" + r) : 8'("0" + r - 26);
	endfunction

	function automatic logic [ID_W-1:0] pick_id();
		if ($urandom_range(4) != 0)
			return id_pool[3'($urandom_range(7))];
		return {pick_id_char(), pick_id_char(), pick_id_char(), pick_id_char()};
	endfunction

	function automatic logic [ID_W-1:0] pick_bad_id();
		logic [ID_W-1:0] id;
		if ($urandom_range(3) == 0)
			return '0;  // padding
		id = pick_id();
		id[8*$urandom_range(3) +: 8] = bad_chars[4'($urandom_range(8))];
		return id;
	endfunction

	// One tag: mostly well formed with random content, now and then cut short
	// by a new start mark, a stray header fragment or raw noise.
	task automatic put_random_tag();
		logic [7:0] fl;
		int unsigned sz;
		tag_beat_t tail;
		fl = 8'($urandom_range(255));
		if ($urandom_range(3) != 0)
			fl[6] = 1'b0;
		put_tag_hdr($urandom_range(19) != 0, 8'($urandom_range(255)),
			8'($urandom_range(255)), fl, SIZE_W'($urandom), 1'b1);
		if (fl[6]) begin
			sz = $urandom_range(5);
			put_syncsafe(SIZE_W'(sz), 1'b1);
			put_payload(sz);
		end
		repeat ($urandom_range(1, 5)) begin
			case ($urandom_range(19))
				0: begin  // frame cut short by the next start mark
					put_frame_hdr(pick_id(), SIZE_W'($urandom), 8'($urandom_range(255)),
						8'($urandom_range(255)));
					put_payload($urandom_range(4));
					return;
				end
				1: begin  // header fragment
					repeat ($urandom_range(1, 9)) put(pick_id_char(), 1'b0);
					return;
				end
				2: begin  // noise, start marks included
					repeat ($urandom_range(1, 12))
						put(8'($urandom_range(255)), $urandom_range(9) == 0);
					return;
				end
				default: begin
					case ($urandom_range(19))
						0:       sz = $urandom_range(100, 300);
						1, 2, 3: sz = $urandom_range(13, 40);
						default: sz = $urandom_range(12);
					endcase
					put_frame_hdr(pick_id(), SIZE_W'(sz), 8'($urandom_range(255)),
						8'($urandom_range(255)));
					put_payload(sz);
				end
			endcase
		end
		if ($urandom_range(1) != 0) begin
			put_frame_hdr(pick_bad_id(), SIZE_W'($urandom), 8'($urandom_range(255)),
				8'($urandom_range(255)));
			// trailing bytes after the end of frames are ignored: not counted
			repeat ($urandom_range(6)) begin
				tail.sot = 1'b0;
				tail.data = 8'($urandom_range(255));
				tag_bytes = {tag_bytes, tail};
			end
		end
	endtask

	task automatic write_ban(input int unsigned idx, input logic [ID_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx[IDX_W-1:0];
		cfg_data <= val;
		if (idx < NUM_BANNED)
			ban_word[idx[BAN_SEL_W-1:0]] = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_bans(input logic [ID_W-1:0] b0, input logic [ID_W-1:0] b1,
			input logic [ID_W-1:0] b2, input logic [ID_W-1:0] b3);
		write_ban(REG_BAN_ID_0, b0);
		write_ban(REG_BAN_ID_1, b1);
		write_ban(REG_BAN_ID_2, b2);
		write_ban(REG_BAN_ID_3, b3);
		@(negedge clk);
	endtask

	// Let the sender empty, then wait for every predicted result, plus a few
	// cycles for bytes that cause none.
	task automatic drain();
		int unsigned guard;
		guard = 0;
		while (tag_bytes.size() != 0 || in_valid)
			@(negedge clk);
		while (parsed_records.size() != 0 && guard < 4000) begin
			@(negedge clk);
			guard++;
		end
		repeat (8) @(negedge clk);
		if (parsed_records.size() != 0) begin
			flag($sformatf("%0d results never arrived, oldest %s",
				parsed_records.size(), show(parsed_records[0])));
			parsed_records.delete();
		end
	endtask

	function automatic logic [ID_W-1:0] pick_ban();
		case ($urandom_range(2))
			0:       return id_pool[3'($urandom_range(7))];
			1:       return $urandom;
			default: return '0;
		endcase
	endfunction

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part; writes past the ban words must not ban anything
		write_ban(REG_NONE_LO, "TIT2");
		write_ban(REG_NONE_HI, "COMM");
		set_bans("PRIV", '0, '0, '0);

		// header before any start mark, all-ones size and version
		put_tag_hdr(1'b0, 8'hFF, 8'h00, 8'hB0, 28'h0FFFFFFF, 1'b0);
		put_frame_hdr("A09Z", 28'd3, 8'hFF, 8'hFF);
		put(8'h00, 1'b0);
		put(8'hFF, 1'b0);
		put(8'h80, 1'b0);
		put_frame_hdr("PRIV", 28'd2, 8'h00, 8'h00);  // banned, skipped
		put_payload(2);
		put_frame_hdr("PRIV", 28'd0, 8'h00, 8'h00);  // banned with nothing to skip
		put_frame_hdr("ZZ99", 28'd0, 8'h00, 8'h00);  // header result only
		put_frame_hdr("TIT2", 28'd4, 8'h70, 8'h4F);
		put_payload(2);                          // start mark in mid-frame
		put_tag_hdr(1'b1, 8'h04, 8'h00, 8'h40, 28'h0, 1'b0);
		put_syncsafe(28'd0, 1'b0);               // empty extended header
		put_frame_hdr("9AZ0", 28'd1, 8'h8F, 8'hB0);
		put_payload(1);
		put_tag_hdr(1'b1, 8'h03, 8'h01, 8'hF0, 28'h5, 1'b1);
		put_syncsafe(28'd3, 1'b1);
		put_payload(3);                          // extended header skipped
		put_frame_hdr("COMM", 28'd1, 8'h00, 8'h00);
		put_payload(1);
		put_frame_hdr("@[/:", 28'd7, 8'h00, 8'h00);  // illegal ID ends the frames
		put_payload(3);                          // ignored
		put(8'h49, 1'b1);                        // start mark in mid-header
		put_payload(4);
		put_tag_hdr(1'b1, 8'h04, 8'h00, 8'h00, 28'h0, 1'b0);
		put_frame_hdr("TPE1", 28'd2, 8'h00, 8'h00);
		put_payload(2);
		put_frame_hdr(32'h0, 28'd0, 8'h00, 8'h00);   // padding
		drain();

		// random part, one ban setting per slice
		stream_len = 0;
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: set_bans('0, '0, '0, '0);
				1: set_bans('1, '1, '1, '1);
				2: set_bans("TIT2", "APIC", "COMM", "PRIV");
				3: set_bans(pick_ban(), pick_ban(), pick_ban(), pick_ban());
				default: begin
					write_ban(REG_NONE_LO + 1, "TPE1");
					write_ban(REG_NONE_HI - 1, "TXXX");
					set_bans("TPE1", '0, "A0Z9", '0);
				end
			endcase
			while (stream_len < (p + 1) * PHASE_BYTES)
				put_random_tag();
			drain();
		end

		$display("Run: %0d bytes accepted over %0d ban settings, with a %0d-cycle receiver hold-off.",
			accepted_cnt, NUM_PHASES + 1, HOLD_CYCLES);
		$display("Results: %0d tag headers, %0d frame headers, %0d payload bytes, %0d frame-area ends.",
			kind_seen[KIND_TAG], kind_seen[KIND_FRAME], kind_seen[KIND_PAYLOAD],
			kind_seen[KIND_END]);
		if (error_cnt == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches in total", error_cnt);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("Timeout: stimulus or results stuck");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> files.f
src/id3_pkg.sv
src/id3_ban_regs.sv
src/id3_parse_core.sv
src/id3_tag_deframer.sv
tb/tb.sv
